// File: hdl/x86ia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86ia_pkg
// Shared types, mode codes and helpers of the x86 integer arithmetic unit.
// ----------------------------------------------------------------------------
package x86ia_pkg;

	localparam logic [3:0] MODE_ADD   = 4'd0;
	localparam logic [3:0] MODE_SUB   = 4'd1;
	localparam logic [3:0] MODE_CMP   = 4'd2;
	localparam logic [3:0] MODE_INC   = 4'd3;
	localparam logic [3:0] MODE_DEC   = 4'd4;
	localparam logic [3:0] MODE_NEG   = 4'd5;
	localparam logic [3:0] MODE_ADC   = 4'd6;
	localparam logic [3:0] MODE_SBB   = 4'd7;
	localparam logic [3:0] MODE_MUL   = 4'd8;
	localparam logic [3:0] MODE_IMUL1 = 4'd9;
	localparam logic [3:0] MODE_IMUL2 = 4'd10;
	localparam logic [3:0] MODE_DIV   = 4'd11;
	localparam logic [3:0] MODE_IDIV  = 4'd12;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_WORD = 2'd1;

	localparam logic [3:0] FMASK_ALL    = 4'hF;
	localparam logic [3:0] FMASK_NO_CF  = 4'hE;
	localparam logic [3:0] FMASK_NONE   = 4'h0;

	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = 8;

	typedef struct packed {
		logic [3:0]  mode;
		logic [1:0]  size;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
		logic        carry_in;
		logic [31:0] acc_low_in;
		logic [31:0] acc_high_in;
	} cmd_t;

	typedef struct packed {
		logic [31:0] result;
		logic        result_write;
		logic [31:0] acc_low_out;
		logic [31:0] acc_high_out;
		logic        carry_flag;
		logic        overflow_flag;
		logic        zero_flag;
		logic        sign_flag;
		logic [3:0]  flag_write_mask;
		logic        divide_error;
	} rsp_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic [1:0]  size;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] r;
		logic        wr;
		logic        cf;
		logic        of;
		logic        zf;
		logic        sf;
		logic [3:0]  fmask;
		logic        neg_n;
		logic        neg_d;
		logic [63:0] nmag;
		logic [31:0] dmag;
		logic        derr;
		logic [63:0] prod;
		logic [31:0] rem;
		logic [31:0] quo;
	} pipe_t;

	function automatic logic [31:0] size_mask(input logic [1:0] size);
		unique case (size)
			SIZE_BYTE: size_mask = 32'h0000_00FF;
			SIZE_WORD: size_mask = 32'h0000_FFFF;
			default:   size_mask = 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] msb_val(input logic [1:0] size);
		unique case (size)
			SIZE_BYTE: msb_val = 32'h0000_0080;
			SIZE_WORD: msb_val = 32'h0000_8000;
			default:   msb_val = 32'h8000_0000;
		endcase
	endfunction

	function automatic logic msb_of(input logic [31:0] v, input logic [1:0] size);
		msb_of = |(v & msb_val(size));
	endfunction

	function automatic logic [31:0] sext32(input logic [31:0] v, input logic [1:0] size);
		sext32 = msb_of(v, size) ? (v | ~size_mask(size)) : (v & size_mask(size));
	endfunction

endpackage

// File: hdl/x86ia_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86ia_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface x86ia_chan_if #(parameter type word_t = logic);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/x86_integer_arith_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_integer_arith_unit_top
// x86 add/sub/cmp/inc/dec/neg/adc/sbb with flags, mul/imul and div/idiv.
// ----------------------------------------------------------------------------
// Takes one instruction word per cycle and returns its response word from the
// last stage: one stage decodes and does the add/sub family, one holds the
// 33x33 multiplier and the divide-error check, eight stages run the restoring
// divider four quotient bits each, and a last stage fixes signs and builds
// EAX/EDX. Every mode travels the full depth, so words leave in order. A stall
// on the response side holds the whole pipeline.
module x86_integer_arith_unit_top (
	input  logic              clk,
	input  logic              arst_n,
	x86ia_chan_if.sink        cmd,
	x86ia_chan_if.source      rsp
);

	localparam int NDIV = x86ia_pkg::DIV_STAGES;

	logic en;

	x86ia_pkg::pipe_t p_n1, p_n2;
	x86ia_pkg::pipe_t p_s1, p_s2;
	logic             v_s1, v_s2;
	x86ia_pkg::pipe_t div_s [NDIV];
	x86ia_pkg::pipe_t div_n [NDIV];
	logic [NDIV-1:0]  div_v_s;
	x86ia_pkg::rsp_t  rsp_n, rsp_s11;
	logic             v_s11;

	assign en = !v_s11 || rsp.ready;
	assign cmd.ready = en;
	assign rsp.valid = v_s11;
	assign rsp.data = rsp_s11;

	// decode, add/sub family, divide operand magnitudes
	always_comb begin
		logic [31:0] mask;
		logic [31:0] a;
		logic [31:0] b;
		logic        c;
		logic        cc;
		logic [32:0] sum;
		logic [32:0] diff;
		logic        cfs;
		logic        cfd;
		logic [63:0] n;
		logic [31:0] dsx;
		logic        idiv;
		logic        arith;
		x86ia_pkg::cmd_t w;
		w = cmd.data;
		mask = x86ia_pkg::size_mask(w.size);
		a = w.operand_a & mask;
		b = w.operand_b & mask;
		c = w.carry_in;
		cc = ((w.mode == x86ia_pkg::MODE_ADC) || (w.mode == x86ia_pkg::MODE_SBB)) ? c : 1'b0;
		sum = {1'b0, a} + {1'b0, b} + {32'd0, cc};
		diff = {1'b0, a} - {1'b0, b} - {32'd0, cc};
		unique case (w.size)
			x86ia_pkg::SIZE_BYTE: cfs = sum[8];
			x86ia_pkg::SIZE_WORD: cfs = sum[16];
			default:              cfs = sum[32];
		endcase
		cfd = diff[32];
		p_n1 = '0;
		p_n1.mode = w.mode;
		p_n1.size = w.size;
		p_n1.a = a;
		p_n1.b = b;
		p_n1.lo = w.acc_low_in;
		p_n1.hi = w.acc_high_in;
		p_n1.cf = c;
		arith = 1'b1;
		unique case (w.mode)
			x86ia_pkg::MODE_ADD, x86ia_pkg::MODE_ADC: begin
				p_n1.r = sum[31:0] & mask;
				p_n1.cf = cfs;
				p_n1.of = x86ia_pkg::msb_of(~(a ^ b) & (a ^ p_n1.r), w.size);
				p_n1.fmask = x86ia_pkg::FMASK_ALL;
				p_n1.wr = 1'b1;
			end
			x86ia_pkg::MODE_SUB, x86ia_pkg::MODE_CMP, x86ia_pkg::MODE_SBB: begin
				p_n1.r = diff[31:0] & mask;
				p_n1.cf = cfd;
				p_n1.of = x86ia_pkg::msb_of((a ^ b) & (a ^ p_n1.r), w.size);
				p_n1.fmask = x86ia_pkg::FMASK_ALL;
				p_n1.wr = (w.mode != x86ia_pkg::MODE_CMP);
			end
			x86ia_pkg::MODE_INC: begin
				p_n1.r = (a + 32'd1) & mask;
				p_n1.of = (p_n1.r == x86ia_pkg::msb_val(w.size));
				p_n1.fmask = x86ia_pkg::FMASK_NO_CF;
				p_n1.wr = 1'b1;
			end
			x86ia_pkg::MODE_DEC: begin
				p_n1.r = (a - 32'd1) & mask;
				p_n1.of = (a == x86ia_pkg::msb_val(w.size));
				p_n1.fmask = x86ia_pkg::FMASK_NO_CF;
				p_n1.wr = 1'b1;
			end
			x86ia_pkg::MODE_NEG: begin
				p_n1.r = (32'd0 - a) & mask;
				p_n1.cf = (a != 32'd0);
				p_n1.of = (a == x86ia_pkg::msb_val(w.size));
				p_n1.fmask = x86ia_pkg::FMASK_ALL;
				p_n1.wr = 1'b1;
			end
			x86ia_pkg::MODE_IMUL2: begin
				arith = 1'b0;
				p_n1.wr = 1'b1;
				p_n1.fmask = x86ia_pkg::FMASK_NONE;
			end
			default: begin
				arith = 1'b0;
				p_n1.fmask = x86ia_pkg::FMASK_NONE;
			end
		endcase
		p_n1.zf = arith & (p_n1.r == 32'd0);
		p_n1.sf = arith & x86ia_pkg::msb_of(p_n1.r, w.size);
		if (!arith) begin
			p_n1.of = 1'b0;
		end
		idiv = (w.mode == x86ia_pkg::MODE_IDIV);
		unique case (w.size)
			x86ia_pkg::SIZE_BYTE:
				n = {{48{idiv & w.acc_low_in[15]}}, w.acc_low_in[15:0]};
			x86ia_pkg::SIZE_WORD:
				n = {{32{idiv & w.acc_high_in[15]}}, w.acc_high_in[15:0], w.acc_low_in[15:0]};
			default:
				n = {w.acc_high_in, w.acc_low_in};
		endcase
		p_n1.neg_n = idiv & n[63];
		p_n1.nmag = p_n1.neg_n ? (64'd0 - n) : n;
		dsx = x86ia_pkg::sext32(a, w.size);
		p_n1.neg_d = idiv & x86ia_pkg::msb_of(a, w.size);
		p_n1.dmag = p_n1.neg_d ? (32'd0 - dsx) : a;
	end

	// multiplier and divide-error check
	always_comb begin
		logic [32:0] x;
		logic [32:0] y;
		logic [65:0] p;
		logic [55:0] hib;
		logic        dmode;
		logic [31:0] lom;
		lom = p_s1.lo & x86ia_pkg::size_mask(p_s1.size);
		if (p_s1.mode == x86ia_pkg::MODE_IMUL1) begin
			x = {1'b0, x86ia_pkg::sext32(p_s1.a, p_s1.size)};
			x[32] = x[31];
			y = {1'b0, x86ia_pkg::sext32(p_s1.lo, p_s1.size)};
			y[32] = y[31];
		end else if (p_s1.mode == x86ia_pkg::MODE_IMUL2) begin
			x = {1'b0, p_s1.a};
			y = {1'b0, p_s1.b};
		end else begin
			x = {1'b0, p_s1.a};
			y = {1'b0, lom};
		end
		p = 66'($signed(x) * $signed(y));
		unique case (p_s1.size)
			x86ia_pkg::SIZE_BYTE: hib = p_s1.nmag[63:8];
			x86ia_pkg::SIZE_WORD: hib = {8'd0, p_s1.nmag[63:16]};
			default:              hib = {24'd0, p_s1.nmag[63:32]};
		endcase
		dmode = (p_s1.mode == x86ia_pkg::MODE_DIV) || (p_s1.mode == x86ia_pkg::MODE_IDIV);
		p_n2 = p_s1;
		p_n2.prod = p[63:0];
		p_n2.derr = dmode & ((p_s1.dmag == 32'd0) || (hib >= {24'd0, p_s1.dmag}));
		p_n2.rem = p_s1.nmag[63:32];
		p_n2.quo = p_s1.nmag[31:0];
	end

	for (genvar g = 0; g < NDIV; g++) begin : g_div
		if (g == 0) begin : g_first
			x86ia_div_steps u_steps (.i_word(p_s2), .o_word(div_n[g]));
		end else begin : g_next
			x86ia_div_steps u_steps (.i_word(div_s[g-1]), .o_word(div_n[g]));
		end
	end

	x86ia_out_stage u_out (.i_word(div_s[NDIV-1]), .o_word(rsp_n));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			div_v_s <= '0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s1 <= cmd.valid;
			v_s2 <= v_s1;
			div_v_s <= {div_v_s[NDIV-2:0], v_s2};
			v_s11 <= div_v_s[NDIV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= p_n1;
			p_s2 <= p_n2;
			for (int k = 0; k < NDIV; k++) begin
				div_s[k] <= div_n[k];
			end
			rsp_s11 <= rsp_n;
		end
	end

endmodule

// File: hdl/x86ia_div_steps.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86ia_div_steps
// DIV_STEPS restoring division steps on the partial remainder and quotient.
// ----------------------------------------------------------------------------
module x86ia_div_steps (
	input  x86ia_pkg::pipe_t i_word,
	output x86ia_pkg::pipe_t o_word
);

	always_comb begin
		logic [32:0] t;
		logic [31:0] rem;
		logic [31:0] quo;
		rem = i_word.rem;
		quo = i_word.quo;
		for (int k = 0; k < x86ia_pkg::DIV_STEPS; k++) begin
			t = {rem, quo[31]};
			quo = {quo[30:0], 1'b0};
			if (t >= {1'b0, i_word.dmag}) begin
				t = t - {1'b0, i_word.dmag};
				quo[0] = 1'b1;
			end
			rem = t[31:0];
		end
		o_word = i_word;
		o_word.rem = rem;
		o_word.quo = quo;
	end

endmodule

// File: hdl/x86ia_top_placeholder_never.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86ia_out_stage
// Final stage: divide sign fix and range check, accumulator and result assembly.
// ----------------------------------------------------------------------------
module x86ia_out_stage (
	input  x86ia_pkg::pipe_t i_word,
	output x86ia_pkg::rsp_t  o_word
);

	always_comb begin
		logic [31:0] mask;
		logic [31:0] msbv;
		logic [31:0] qs;
		logic [31:0] rs;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] r;
		logic        bad;
		logic        derr;
		mask = x86ia_pkg::size_mask(i_word.size);
		msbv = x86ia_pkg::msb_val(i_word.size);
		lo = i_word.lo;
		hi = i_word.hi;
		r = i_word.r;
		if (i_word.neg_n != i_word.neg_d) begin
			bad = i_word.quo > msbv;
		end else begin
			bad = i_word.quo > (msbv - 32'd1);
		end
		derr = i_word.derr | ((i_word.mode == x86ia_pkg::MODE_IDIV) & bad);
		qs = ((i_word.neg_n != i_word.neg_d) ? (32'd0 - i_word.quo) : i_word.quo) & mask;
		rs = (i_word.neg_n ? (32'd0 - i_word.rem) : i_word.rem) & mask;
		unique case (i_word.mode)
			x86ia_pkg::MODE_MUL, x86ia_pkg::MODE_IMUL1: begin
				if (i_word.size == x86ia_pkg::SIZE_BYTE) begin
					lo = {i_word.lo[31:16], i_word.prod[15:0]};
				end else if (i_word.size == x86ia_pkg::SIZE_WORD) begin
					lo = {i_word.lo[31:16], i_word.prod[15:0]};
					hi = {i_word.hi[31:16], i_word.prod[31:16]};
				end else begin
					lo = i_word.prod[31:0];
					hi = i_word.prod[63:32];
				end
			end
			x86ia_pkg::MODE_IMUL2: begin
				r = i_word.prod[31:0] & mask;
			end
			x86ia_pkg::MODE_DIV, x86ia_pkg::MODE_IDIV: begin
				if (!derr) begin
					if (i_word.size == x86ia_pkg::SIZE_BYTE) begin
						lo = {i_word.lo[31:16], rs[7:0], qs[7:0]};
					end else if (i_word.size == x86ia_pkg::SIZE_WORD) begin
						lo = {i_word.lo[31:16], qs[15:0]};
						hi = {i_word.hi[31:16], rs[15:0]};
					end else begin
						lo = qs;
						hi = rs;
					end
				end
			end
			default: begin
			end
		endcase
		o_word.result = i_word.wr ? r : 32'd0;
		o_word.result_write = i_word.wr;
		o_word.acc_low_out = lo;
		o_word.acc_high_out = hi;
		o_word.carry_flag = i_word.cf;
		o_word.overflow_flag = i_word.of;
		o_word.zero_flag = i_word.zf;
		o_word.sign_flag = i_word.sf;
		o_word.flag_write_mask = i_word.fmask;
		o_word.divide_error = derr;
	end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the x86 integer arithmetic unit.
// ----------------------------------------------------------------------------
// Instruction words go in over the command channel and each response word is
// compared as a whole word against a predictor kept in this bench. Directed
// corner cases come first, then a shared task run per instruction family, then a
// long random mix. Both channels idle in random bursts, except in the last part.
// ----------------------------------------------------------------------------
module tb_top;
	import x86ia_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	x86ia_chan_if #(.word_t(cmd_t)) cmd_ch ();
	x86ia_chan_if #(.word_t(rsp_t)) rsp_ch ();

	x86_integer_arith_unit_top dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch.sink), .rsp(rsp_ch.source)
	);

	always #5 clk = ~clk;

	rsp_t   expected_rsps[$];
	int     errors = 0;
	int     sent = 0;
	int     checked = 0;
	int     derr_seen = 0;
	longint cycles = 0;
	bit     calm = 1'b0;
	int     sink_idle = 0;

	localparam longint CYCLE_LIMIT = 200000;

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		rsp_ch.ready = 1'b0;
	end

	function automatic logic [63:0] sx64(input logic [63:0] v, input int bits);
		logic [63:0] m;
		if (bits >= 64) return v;
		m = (64'd1 << bits) - 64'd1;
		v &= m;
		return v[bits-1] ? (v | ~m) : v;
	endfunction

	function automatic rsp_t predict_alu(input cmd_t c);
		rsp_t   o;
		int     bits;
		logic [63:0] msk, msb, a, b, ci, lo, hi, r, full, p, n, d, q, rm;
		logic   cf, of, arith, nn, nd, bad;
		logic [3:0] fm;
		logic   wr, de;
		bits = (c.size == 2'd0) ? 8 : (c.size == 2'd1) ? 16 : 32;
		msk = (64'd1 << bits) - 64'd1;
		msb = 64'd1 << (bits - 1);
		a = c.operand_a & msk;
		b = c.operand_b & msk;
		ci = {63'd0, c.carry_in};
		lo = {32'd0, c.acc_low_in};
		hi = {32'd0, c.acc_high_in};
		r = 0; cf = c.carry_in; of = 0; fm = FMASK_NONE; wr = 0; de = 0; arith = 1;
		nn = 0; nd = 0;
		case (c.mode)
			MODE_ADD, MODE_ADC: begin
				full = a + b + ((c.mode == MODE_ADC) ? ci : 64'd0);
				r = full & msk;
				cf = full[bits];
				of = |(~(a ^ b) & (a ^ r) & msb);
				fm = FMASK_ALL; wr = 1;
			end
			MODE_SUB, MODE_CMP, MODE_SBB: begin
				full = (c.mode == MODE_SBB) ? ci : 64'd0;
				r = (a - b - full) & msk;
				cf = a < b + full;
				of = |((a ^ b) & (a ^ r) & msb);
				fm = FMASK_ALL; wr = (c.mode != MODE_CMP);
			end
			MODE_INC: begin
				r = (a + 1) & msk; of = (r == msb); fm = FMASK_NO_CF; wr = 1;
			end
			MODE_DEC: begin
				r = (a - 1) & msk; of = (a == msb); fm = FMASK_NO_CF; wr = 1;
			end
			MODE_NEG: begin
				r = (0 - a) & msk; cf = (a != 0); of = (a == msb); fm = FMASK_ALL; wr = 1;
			end
			MODE_MUL, MODE_IMUL1: begin
				arith = 0;
				if (c.mode == MODE_MUL) p = a * (lo & msk);
				else p = sx64(a, bits) * sx64(lo, bits);
				if (bits == 8) lo = (lo & 64'hFFFF0000) | (p & 64'hFFFF);
				else if (bits == 16) begin
					lo = (lo & 64'hFFFF0000) | (p & 64'hFFFF);
					hi = (hi & 64'hFFFF0000) | ((p >> 16) & 64'hFFFF);
				end else begin
					lo = p & 64'hFFFFFFFF;
					hi = (p >> 32) & 64'hFFFFFFFF;
				end
			end
			MODE_IMUL2: begin
				arith = 0; r = (a * b) & msk; wr = 1;
			end
			MODE_DIV, MODE_IDIV: begin
				arith = 0;
				if (bits == 8) n = lo & 64'hFFFF;
				else if (bits == 16) n = ((hi & 64'hFFFF) << 16) | (lo & 64'hFFFF);
				else n = (hi << 32) | lo;
				d = a;
				if (c.mode == MODE_IDIV) begin
					n = sx64(n, bits * 2);
					d = sx64(a, bits);
					nn = n[63]; nd = d[63];
					if (nn) n = 0 - n;
					if (nd) d = 0 - d;
				end
				if (d == 0) de = 1;
				else begin
					q = n / d; rm = n % d;
					if (c.mode == MODE_DIV) bad = q > msk;
					else if (nn != nd) bad = q > msb;
					else bad = q > msb - 1;
					if (bad) de = 1;
					else begin
						if (nn != nd) q = 0 - q;
						if (nn) rm = 0 - rm;
						q &= msk; rm &= msk;
						if (bits == 8) lo = (lo & 64'hFFFF0000) | (rm << 8) | q;
						else if (bits == 16) begin
							lo = (lo & 64'hFFFF0000) | q;
							hi = (hi & 64'hFFFF0000) | rm;
						end else begin
							lo = q; hi = rm;
						end
					end
				end
			end
			default: arith = 0;
		endcase
		o.result = wr ? r[31:0] : 32'd0;
		o.result_write = wr;
		o.acc_low_out = lo[31:0];
		o.acc_high_out = hi[31:0];
		o.carry_flag = fm[0] ? cf : c.carry_in;
		o.overflow_flag = arith ? of : 1'b0;
		o.zero_flag = arith ? (r == 0) : 1'b0;
		o.sign_flag = arith ? |(r & msb) : 1'b0;
		o.flag_write_mask = fm;
		o.divide_error = de;
		return o;
	endfunction

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return {24'd0, 8'h80} << (8 * $urandom_range(0, 3));
			3: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input cmd_t c);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		expected_rsps.push_back(predict_alu(c));
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		do @(posedge clk); while (!cmd_ch.ready);
		sent++;
	endtask

	task automatic send_op(input logic [3:0] m, input logic [1:0] s, input logic [31:0] a,
			input logic [31:0] b, input logic ci, input logic [31:0] lo, input logic [31:0] hi);
		cmd_t c;
		c.mode = m; c.size = s; c.operand_a = a; c.operand_b = b;
		c.carry_in = ci; c.acc_low_in = lo; c.acc_high_in = hi;
		send_word(c);
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (expected_rsps.size() != 0) @(posedge clk);
	endtask

	task automatic test_corners();
		send_op(MODE_ADD, 2'd0, 32'hFF, 32'h01, 0, 0, 0);
		send_op(MODE_ADD, 2'd1, 32'h7FFF, 32'h1, 0, 0, 0);
		send_op(MODE_ADD, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
		send_op(MODE_SUB, 2'd0, 32'h0, 32'h1, 0, 0, 0);
		send_op(MODE_SUB, 2'd2, 32'h8000_0000, 32'h1, 0, 0, 0);
		send_op(MODE_CMP, 2'd1, 32'h1234, 32'h1234, 1, 0, 0);
		send_op(MODE_INC, 2'd0, 32'h7F, 0, 1, 0, 0);
		send_op(MODE_DEC, 2'd1, 32'h8000, 0, 0, 0, 0);
		send_op(MODE_NEG, 2'd2, 32'h8000_0000, 0, 0, 0, 0);
		send_op(MODE_NEG, 2'd0, 32'h0, 0, 1, 0, 0);
		send_op(MODE_ADC, 2'd0, 32'hFF, 32'h0, 1, 0, 0);
		send_op(MODE_SBB, 2'd2, 32'h0, 32'hFFFF_FFFF, 1, 0, 0);
		send_op(MODE_MUL, 2'd2, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 32'h1234_5678);
		send_op(MODE_IMUL1, 2'd0, 32'h80, 0, 0, 32'hAAAA_AA80, 32'h5555_5555);
		send_op(MODE_IMUL1, 2'd1, 32'hFFFF, 0, 1, 32'hDEAD_8000, 32'hBEEF_0000);
		send_op(MODE_IMUL2, 2'd2, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0);
		send_op(MODE_DIV, 2'd0, 32'h0, 0, 0, 32'h1234, 0);
		send_op(MODE_DIV, 2'd0, 32'h1, 0, 0, 32'h0100, 0);
		send_op(MODE_DIV, 2'd2, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
		send_op(MODE_IDIV, 2'd2, 32'hFFFF_FFFF, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF);
		send_op(MODE_IDIV, 2'd0, 32'hFF, 0, 0, 32'hFF80, 0);
		send_op(MODE_IDIV, 2'd1, 32'h7, 0, 0, 32'hFFF9, 32'hFFFF);
		send_op(4'd13, 2'd1, 32'h1, 32'h2, 1, 32'h3, 32'h4);
		send_op(4'd15, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'h5, 32'h6);
		send_op(MODE_ADD, 2'd3, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
	endtask

	task automatic test_family(input logic [3:0] lo_m, input logic [3:0] hi_m, input int count);
		cmd_t c;
		repeat (count) begin
			c.mode = $urandom_range(lo_m, hi_m);
			c.size = $urandom_range(0, 3);
			c.operand_a = rand_val();
			c.operand_b = rand_val();
			c.carry_in = $urandom_range(0, 1);
			c.acc_low_in = rand_val();
			c.acc_high_in = rand_val();
			if ((c.mode == MODE_DIV || c.mode == MODE_IDIV) && $urandom_range(0, 2) != 0)
				c.acc_high_in = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
			send_word(c);
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d words outstanding", $time, expected_rsps.size());
			$display("FAIL");
			$finish;
		end
	end

	// response side: checks each word, with random stall bursts until calm
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t unexpected word %p", $time, rsp_ch.data);
					errors++;
				end else begin
					rsp_t e;
					e = expected_rsps.pop_front();
					checked++;
					if (e.divide_error) derr_seen++;
					if (rsp_ch.data !== e) begin
						errors++;
						$display("%0t mismatch expected %p", $time, e);
						$display("%0t          actual   %p", $time, rsp_ch.data);
					end
				end
			end
			if (!calm && sink_idle > 0) begin
				sink_idle <= sink_idle - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				sink_idle <= $urandom_range(0, 15);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		test_family(MODE_ADD, MODE_SBB, 200);
		wait_drained();
		test_family(MODE_MUL, MODE_IMUL2, 120);
		test_family(MODE_DIV, MODE_IDIV, 180);
		test_family(4'd0, 4'd15, 150);
		wait_drained();
		calm = 1'b1;
		test_family(4'd0, 4'd15, 100);
		wait_drained();
		repeat (30) @(posedge clk);
		$display("sent %0d instruction words, checked %0d responses (%0d divide errors)",
			sent, checked, derr_seen);
		$display("covered add/sub family flags, mul/imul, div/idiv and unknown modes");
		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
